// File: rtl/fcw_pkg.sv
`default_nettype none

package fcw_pkg;

    localparam int CHAR_W   = 7;
    localparam int POS_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int MAX_KEEP = 127;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [BYTE_W-1:0] t_byte;

    // item as it travels from the tracking stage to the match stage
    typedef struct packed {
        t_char ch;
        logic  word_end;
        logic  first;
        t_pos  pos;
        t_pos  prev_len;
    } t_item;

    // access to the character memory, issued with the input transfer
    typedef struct packed {
        logic  rd_en;
        logic  wr_en;
        t_pos  addr;
        t_char wdata;
    } t_mem_req;

    // one byte pushed to the output queue
    typedef struct packed {
        logic  valid;
        t_byte out_byte;
        logic  last;
    } t_push;

    typedef struct packed {
        t_byte out_byte;
        logic  last;
    } t_out_word;

    // prefix marker: 128 + n
    function automatic t_byte mark_byte(input t_pos n);
        mark_byte = {1'b1, n};
    endfunction

endpackage

`default_nettype wire

// File: rtl/fcw_if.sv
`default_nettype none

interface fcw_in_if import fcw_pkg::*; ();
    logic  valid;
    logic  ready;
    t_char ch;
    logic  word_end;

    modport source (output valid, output ch, output word_end, input ready);
    modport sink   (input valid, input ch, input word_end, output ready);
endinterface

interface fcw_out_if import fcw_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/fcw_char_mem.sv
`default_nettype none

module fcw_char_mem import fcw_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_char         o_rdata
);

    t_char r_mem [0:MAX_KEEP-1];
    t_char r_rdata;

    // read returns the old entry when the same entry is written
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/fcw_track.sv
`default_nettype none

module fcw_track import fcw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fcw_in_if.sink    i_in,
    input  wire logic i_free,
    output logic      o_load,
    output t_item     o_item,
    output t_mem_req  o_req
);

    t_pos r_pos;
    t_pos r_plen;
    logic r_first;
    logic w_acc;
    logic w_keep;

    assign i_in.ready = i_free;
    assign w_acc      = i_in.valid && i_free;
    assign w_keep     = (r_pos < POS_W'(MAX_KEEP));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_plen  <= '0;
            r_first <= 1'b1;
        end else if (w_acc) begin
            if (i_in.word_end) begin
                r_plen  <= r_pos;
                r_pos   <= '0;
                r_first <= 1'b0;
            end else if (w_keep) begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    always_comb begin
        o_load          = w_acc;
        o_item.ch       = i_in.ch;
        o_item.word_end = i_in.word_end;
        o_item.first    = r_first;
        o_item.pos      = r_pos;
        o_item.prev_len = r_plen;
        // old entry is read and the new character written in one access
        o_req.rd_en     = w_acc && !i_in.word_end && w_keep;
        o_req.wr_en     = w_acc && !i_in.word_end && w_keep;
        o_req.addr      = r_pos;
        o_req.wdata     = i_in.ch;
    end

endmodule

`default_nettype wire

// File: rtl/fcw_match.sv
`default_nettype none

module fcw_match import fcw_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_item i_item,
    input  wire t_char i_rdata,
    input  wire logic  i_full,
    output logic       o_free,
    output t_push      o_push
);

    logic       r_valid;
    t_item      r_item;
    logic       r_phase;
    logic       r_still;

    logic       w_same;
    logic [1:0] w_cnt;
    t_byte      w_b0;
    t_byte      w_b1;
    logic       w_next_still;
    logic       w_last;
    logic       w_push;
    logic       w_done;

    assign w_same = (r_item.pos < r_item.prev_len)
                 && (r_item.pos < POS_W'(MAX_KEEP))
                 && (i_rdata == r_item.ch);

    always_comb begin
        w_cnt        = 2'd1;
        w_b0         = {1'b0, r_item.ch};
        w_b1         = {1'b0, r_item.ch};
        w_next_still = r_still;
        priority if (r_item.word_end) begin
            w_cnt        = (!r_item.first && r_still) ? 2'd1 : 2'd0;
            w_b0         = mark_byte(r_item.pos);
            w_next_still = 1'b1;
        end else if (r_item.first) begin
            w_cnt = 2'd1;
        end else if (r_still && w_same) begin
            // marker goes out once the match fills the whole store
            if (r_item.pos == POS_W'(MAX_KEEP - 1)) begin
                w_cnt        = 2'd1;
                w_b0         = mark_byte(POS_W'(MAX_KEEP));
                w_next_still = 1'b0;
            end else begin
                w_cnt = 2'd0;
            end
        end else if (r_still) begin
            w_cnt        = 2'd2;
            w_b0         = mark_byte(r_item.pos);
            w_next_still = 1'b0;
        end else begin
            w_cnt = 2'd1;
        end
    end

    assign w_last = (w_cnt == 2'd1) || r_phase;
    assign w_push = r_valid && (w_cnt != 2'd0) && !i_full;
    assign w_done = r_valid && ((w_cnt == 2'd0) || (w_push && w_last));

    assign o_free          = !r_valid || w_done;
    assign o_push.valid    = w_push;
    assign o_push.out_byte = r_phase ? w_b1 : w_b0;
    assign o_push.last     = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
            r_still <= 1'b1;
        end else begin
            if (i_load) begin
                r_valid <= 1'b1;
            end else if (w_done) begin
                r_valid <= 1'b0;
            end
            if (w_done) begin
                r_phase <= 1'b0;
                r_still <= w_next_still;
            end else if (w_push) begin
                r_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fcw_out_fifo.sv
`default_nettype none

module fcw_out_fifo import fcw_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_full,
    fcw_out_if.source  o_out
);

    t_out_word  r_mem [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign w_pop          = o_out.valid && o_out.ready;
    assign o_full         = (r_cnt == 2'd2);
    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.out_byte = r_mem[r_rp].out_byte;
    assign o_out.last     = r_mem[r_rp].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({i_push.valid, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp].out_byte <= i_push.out_byte;
            r_mem[r_wp].last     <= i_push.last;
        end
    end

endmodule

`default_nettype wire

// File: rtl/front_coding_word_encoder.sv
// channel   dir   payload               transfer
// i_in      in    ch[7], word_end[1]    valid && ready
// o_out     out   out_byte[8], last[1]  valid && ready
//
// one item per cycle while the output queue has room; a two-byte item
// (marker and character) holds the match stage for both single-byte queue writes
// each character item below position 127 does one read-and-write of the 127-entry
// character memory; the next cycle compares the registered read data
// synchronous active-low reset, no clearing pass; stalls on o_out back up
// through a two-entry output queue into the input ready
`default_nettype none

module front_coding_word_encoder import fcw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fcw_in_if.sink    i_in,
    fcw_out_if.source o_out
);

    logic     w_free;
    logic     w_load;
    t_item    w_item;
    t_mem_req w_req;
    t_char    w_rdata;
    logic     w_full;
    t_push    w_push;

    fcw_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_free  (w_free),
        .o_load  (w_load),
        .o_item  (w_item),
        .o_req   (w_req)
    );

    fcw_char_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    fcw_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_item  (w_item),
        .i_rdata (w_rdata),
        .i_full  (w_full),
        .o_free  (w_free),
        .o_push  (w_push)
    );

    fcw_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
